/* hdl/morse_key_decoder_defines.svh */
// Assertion macros shared by the Morse key decoder modules.
`ifndef MORSE_KEY_DECODER_DEFINES_SVH
`define MORSE_KEY_DECODER_DEFINES_SVH

// Checked on every edge outside reset; needs clk and rst_n in scope.
`define MKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MKD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mkd_pkg.sv */
// Shared types, constants and the letter table for the Morse key decoder.
package mkd_pkg;

  localparam int COUNT_WIDTH  = 24;
  localparam int CFG_WIDTH    = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_ELEMENTS = 4;
  localparam int CODE_WIDTH   = 4;
  localparam int LEN_WIDTH    = 3;
  localparam int SYM_WIDTH    = 7;
  localparam int KIND_WIDTH   = 2;

  localparam logic [LEN_WIDTH-1:0] MAX_LEN = LEN_WIDTH'(MAX_ELEMENTS);

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_THRESHOLD = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DASH_THRESHOLD_RST   = 24'd90000;
  localparam logic [CFG_WIDTH-1:0] GAP_TIMEOUT_RST      = 24'd300000;
  localparam logic [CFG_WIDTH-1:0] BUTTON_THRESHOLD_RST = 24'd30000;

  localparam logic [SYM_WIDTH-1:0] SYM_NONE      = 7'd0;
  localparam logic [SYM_WIDTH-1:0] SYM_SPACE     = 7'd32;
  localparam logic [SYM_WIDTH-1:0] SYM_BACKSPACE = 7'd8;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_LETTER    = 2'd0,
    KIND_SPACE     = 2'd1,
    KIND_BACKSPACE = 2'd2,
    KIND_INVALID   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [SYM_WIDTH-1:0] symbol;
    kind_t                kind;
    logic                 last;
  } result_t;

  // Up to two results from one tick
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_res_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH-1:0] r;
    r = (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

  // Letters by length: base of length n is 2^n - 2, code appended.
  function automatic logic [SYM_WIDTH-1:0] letter_lookup(
    input logic [CODE_WIDTH-1:0] code,
    input logic [LEN_WIDTH-1:0]  len
  );
    logic [4:0]           idx;
    logic                 ok;
    logic [SYM_WIDTH-1:0] s;
    ok  = 1'b1;
    idx = '0;
    s   = SYM_NONE;
    case (len)
      3'd1:    idx = 5'd0  + {4'd0, code[0]};
      3'd2:    idx = 5'd2  + {3'd0, code[1:0]};
      3'd3:    idx = 5'd6  + {2'd0, code[2:0]};
      3'd4:    idx = 5'd14 + {1'b0, code};
      default: ok  = 1'b0;
    endcase
    if (ok) begin
      case (idx)
        5'd0:    s = 7'd69;  // E
        5'd1:    s = 7'd84;  // T
        5'd2:    s = 7'd73;  // I
        5'd3:    s = 7'd65;  // A
        5'd4:    s = 7'd78;  // N
        5'd5:    s = 7'd77;  // M
        5'd6:    s = 7'd83;  // S
        5'd7:    s = 7'd85;  // U
        5'd8:    s = 7'd82;  // R
        5'd9:    s = 7'd87;  // W
        5'd10:   s = 7'd68;  // D
        5'd11:   s = 7'd75;  // K
        5'd12:   s = 7'd71;  // G
        5'd13:   s = 7'd79;  // O
        5'd14:   s = 7'd72;  // H
        5'd15:   s = 7'd86;  // V
        5'd16:   s = 7'd70;  // F
        5'd18:   s = 7'd76;  // L
        5'd20:   s = 7'd80;  // P
        5'd21:   s = 7'd74;  // J
        5'd22:   s = 7'd66;  // B
        5'd23:   s = 7'd88;  // X
        5'd24:   s = 7'd67;  // C
        5'd25:   s = 7'd89;  // Y
        5'd26:   s = 7'd90;  // Z
        5'd27:   s = 7'd81;  // Q
        default: s = SYM_NONE;
      endcase
    end
    return s;
  endfunction

endpackage

/* hdl/mkd_step.sv */
// Key timing, element collection, letter decode and button handling; one tick per enable.
`include "morse_key_decoder_defines.svh"

module mkd_step
  import mkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  input  logic                 en,
  input  logic                 key_down,
  input  logic                 space_pressed,
  input  logic                 delete_pressed,
  output step_res_t            res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PRESS = 2'd1,
    PH_GAP   = 2'd2
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]  hold_count_r, hold_count_nxt;
  logic [COUNT_WIDTH-1:0]  gap_count_r, gap_count_nxt;
  logic [CODE_WIDTH-1:0]   code_bits_r, code_bits_nxt;
  logic [LEN_WIDTH-1:0]    code_len_r, code_len_nxt;
  logic [COUNT_WIDTH-1:0]  space_hold_r, space_hold_nxt;
  logic [COUNT_WIDTH-1:0]  delete_hold_r, delete_hold_nxt;
  logic [CFG_WIDTH-1:0]    dash_thr_r, gap_tmo_r, btn_thr_r;

  logic [CODE_WIDTH-1:0]   bits_tmp;
  logic [LEN_WIDTH-1:0]    len_tmp;
  logic [COUNT_WIDTH-1:0]  gap_inc;
  logic                    emit;
  logic [SYM_WIDTH-1:0]    letter;
  logic                    sp_fire, del_fire;

  always_comb begin
    phase_nxt       = phase_r;
    hold_count_nxt  = hold_count_r;
    gap_count_nxt   = gap_count_r;
    code_bits_nxt   = code_bits_r;
    code_len_nxt    = code_len_r;
    space_hold_nxt  = space_hold_r;
    delete_hold_nxt = delete_hold_r;
    bits_tmp        = code_bits_r;
    len_tmp         = code_len_r;
    gap_inc         = sat_inc(gap_count_r);
    emit            = 1'b0;
    sp_fire         = 1'b0;
    del_fire        = 1'b0;

    if (en) begin
      case (phase_r)
        PH_PRESS: begin
          if (key_down) begin
            hold_count_nxt = sat_inc(hold_count_r);
          end else begin
            // exactly on the threshold is still a dot
            bits_tmp       = {code_bits_r[CODE_WIDTH-2:0], (hold_count_r > dash_thr_r)};
            len_tmp        = code_len_r + 1'b1;
            hold_count_nxt = '0;
            code_bits_nxt  = bits_tmp;
            code_len_nxt   = len_tmp;
            if (len_tmp >= MAX_LEN) begin
              emit = 1'b1;
            end else begin
              phase_nxt     = PH_GAP;
              gap_count_nxt = '0;
            end
          end
          space_hold_nxt  = '0;
          delete_hold_nxt = '0;
        end
        PH_GAP: begin
          if (key_down) begin
            phase_nxt      = PH_PRESS;
            hold_count_nxt = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            gap_count_nxt  = '0;
          end else begin
            gap_count_nxt = gap_inc;
            if (gap_inc >= gap_tmo_r) begin
              emit = 1'b1;
            end
          end
          space_hold_nxt  = '0;
          delete_hold_nxt = '0;
        end
        default: begin
          // idle, and the spare phase code
          phase_nxt = PH_IDLE;
          if (key_down) begin
            phase_nxt       = PH_PRESS;
            hold_count_nxt  = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            code_bits_nxt   = '0;
            code_len_nxt    = '0;
            space_hold_nxt  = '0;
            delete_hold_nxt = '0;
          end else begin
            if (space_pressed) begin
              space_hold_nxt = sat_inc(space_hold_r);
            end else begin
              sp_fire        = (space_hold_r > btn_thr_r);
              space_hold_nxt = '0;
            end
            if (delete_pressed) begin
              delete_hold_nxt = sat_inc(delete_hold_r);
            end else begin
              del_fire        = (delete_hold_r > btn_thr_r);
              delete_hold_nxt = '0;
            end
          end
        end
      endcase

      if (emit) begin
        code_bits_nxt  = '0;
        code_len_nxt   = '0;
        gap_count_nxt  = '0;
        hold_count_nxt = '0;
        phase_nxt      = PH_IDLE;
      end
    end
  end

  assign letter = letter_lookup(bits_tmp, len_tmp);

  // Result slots: a letter, or space and/or backspace (space first)
  always_comb begin
    res = '0;
    if (emit) begin
      res.n         = 2'd1;
      res.r0.symbol = letter;
      res.r0.kind   = (letter == SYM_NONE) ? KIND_INVALID : KIND_LETTER;
      res.r0.last   = 1'b1;
    end else if (sp_fire && del_fire) begin
      res.n         = 2'd2;
      res.r0.symbol = SYM_SPACE;
      res.r0.kind   = KIND_SPACE;
      res.r0.last   = 1'b0;
      res.r1.symbol = SYM_BACKSPACE;
      res.r1.kind   = KIND_BACKSPACE;
      res.r1.last   = 1'b1;
    end else if (sp_fire) begin
      res.n         = 2'd1;
      res.r0.symbol = SYM_SPACE;
      res.r0.kind   = KIND_SPACE;
      res.r0.last   = 1'b1;
    end else if (del_fire) begin
      res.n         = 2'd1;
      res.r0.symbol = SYM_BACKSPACE;
      res.r0.kind   = KIND_BACKSPACE;
      res.r0.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      hold_count_r  <= '0;
      gap_count_r   <= '0;
      code_bits_r   <= '0;
      code_len_r    <= '0;
      space_hold_r  <= '0;
      delete_hold_r <= '0;
      dash_thr_r    <= DASH_THRESHOLD_RST;
      gap_tmo_r     <= GAP_TIMEOUT_RST;
      btn_thr_r     <= BUTTON_THRESHOLD_RST;
    end else begin
      phase_r       <= phase_nxt;
      hold_count_r  <= hold_count_nxt;
      gap_count_r   <= gap_count_nxt;
      code_bits_r   <= code_bits_nxt;
      code_len_r    <= code_len_nxt;
      space_hold_r  <= space_hold_nxt;
      delete_hold_r <= delete_hold_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DASH_THRESHOLD:   dash_thr_r <= cfg_wdata;
          CFG_GAP_TIMEOUT:      gap_tmo_r  <= cfg_wdata;
          CFG_BUTTON_THRESHOLD: btn_thr_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  `MKD_ASSERT(a_press_hold_nonzero, (phase_r == PH_PRESS) |-> (hold_count_r != '0), "key press phase with zero hold count")
  `MKD_ASSERT(a_len_bounded, (phase_r != PH_IDLE) |-> (code_len_r < MAX_LEN), "element count reached limit without decode")
  `MKD_ASSERT(a_buttons_clear, (phase_r != PH_IDLE) |-> (space_hold_r == '0 && delete_hold_r == '0), "button hold counting during a letter")

endmodule

/* hdl/mkd_fifo.sv */
// Four-entry result queue taking up to two beats per cycle and giving one.
`include "morse_key_decoder_defines.svh"

module mkd_fifo
  import mkd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic [1:0] push_n,
  input  result_t   push_r0,
  input  result_t   push_r1,
  input  logic      pop,
  output logic      head_valid,
  output result_t   head,
  output logic      room2
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   wr_ptr1;

  assign wr_ptr1    = wr_ptr_r + 1'b1;
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign room2      = (count_r <= CNT_W'(DEPTH - 2));
  assign count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= push_r0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= push_r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `MKD_ASSERT(a_count_bounded, count_r <= CNT_W'(DEPTH), "result queue count beyond depth")
  `MKD_ASSERT(a_push_room, (push_n != 2'd0) |-> room2, "results pushed without two free slots")
  `MKD_ASSERT(a_pop_nonempty, pop |-> head_valid, "pop from empty result queue")

endmodule

/* hdl/morse_key_decoder.sv */
// Top level of the Morse key decoder: input register, decode step and result queue.
// One key/button sample per beat, one beat a cycle. A sample is held in an input
// register, processed by the step logic once the queue has two free slots, and
// its results land in a four-entry queue whose head drives out_valid. Most
// samples give no result; a letter (or an invalid code, kind 3 with symbol zero)
// comes out when the key has stayed up for gap_timeout ticks after an element or
// as soon as the fourth element is released. Space and backspace come on button
// release after a hold beyond button_threshold; releasing both on the same tick
// gives two beats, space first, last set on the second. Samples are taken every
// cycle while the queue has two free slots; the queue drains one beat a cycle,
// so in_stall rises only when out_stall holds the queue back. Config registers
// (index 0 dash threshold, 1 gap timeout, 2 button threshold) are plain writes,
// meant for when the block is idle.
module morse_key_decoder
  import mkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // config
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_key_down,
  input  logic                 in_space_pressed,
  input  logic                 in_delete_pressed,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SYM_WIDTH-1:0] out_symbol,
  output logic [KIND_WIDTH-1:0] out_kind,
  output logic                 out_last
);

  logic      in_valid_r;
  logic      key_r, space_r, delete_r;
  logic      in_take;
  logic      step_en;
  logic      room2;
  logic      pop;
  step_res_t step_res;
  result_t   head;
  logic [1:0] push_n;

  // Held sample moves on when the queue can absorb a two-beat tick
  assign step_en  = in_valid_r && room2;
  assign in_stall = in_valid_r && !room2;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      key_r    <= in_key_down;
      space_r  <= in_space_pressed;
      delete_r <= in_delete_pressed;
    end
  end

  mkd_step u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .en             (step_en),
    .key_down       (key_r),
    .space_pressed  (space_r),
    .delete_pressed (delete_r),
    .res            (step_res)
  );

  assign push_n = step_res.n;
  assign pop    = out_valid && !out_stall;

  mkd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_r0    (step_res.r0),
    .push_r1    (step_res.r1),
    .pop        (pop),
    .head_valid (out_valid),
    .head       (head),
    .room2      (room2)
  );

  assign out_symbol = head.symbol;
  assign out_kind   = head.kind;
  assign out_last   = head.last;

endmodule

/* verif/tb_morse_key_decoder.sv */
// Self-checking testbench for the Morse key decoder: paced key and button beats, every result scored.
module tb_morse_key_decoder;
  import mkd_pkg::*;

  // Index 3 sits past the register list; writes to it must leave everything alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam logic [CFG_WIDTH-1:0] CFG_ALL_ONES    = '1;
  // Cycles of slack once the last result is in: input register plus step stage, with margin
  localparam int PIPE_SLACK  = 6;
  // Cycles with no beat on either channel before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // Letters by code length: block of length n starts at 2^n - 2; '.' marks a non-letter
  localparam logic [8*30-1:0] MORSE_CHARS = "ETIANMSURWDKGOHVF.L.PJBXCYZQ..";

  typedef enum logic [1:0] {KEY_IDLE, KEY_HELD, KEY_GAP} key_mode_t;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_WIDTH-1:0]  cfg_wdata         = '0;
  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  logic                  in_key_down       = 1'b0;
  logic                  in_space_pressed  = 1'b0;
  logic                  in_delete_pressed = 1'b0;
  logic                  out_valid;
  logic                  out_stall         = 1'b0;
  logic [SYM_WIDTH-1:0]  out_symbol;
  logic [KIND_WIDTH-1:0] out_kind;
  logic                  out_last;

  // Decoder image kept alongside the block, advanced once per accepted sample
  logic [CFG_WIDTH-1:0]   dash_thr    = DASH_THRESHOLD_RST;
  logic [CFG_WIDTH-1:0]   gap_to      = GAP_TIMEOUT_RST;
  logic [CFG_WIDTH-1:0]   btn_thr     = BUTTON_THRESHOLD_RST;
  key_mode_t              mode        = KEY_IDLE;
  logic [COUNT_WIDTH-1:0] hold_ticks  = '0;
  logic [COUNT_WIDTH-1:0] gap_ticks   = '0;
  logic [COUNT_WIDTH-1:0] space_ticks = '0;
  logic [COUNT_WIDTH-1:0] del_ticks   = '0;
  logic [CODE_WIDTH-1:0]  code_bits   = '0;
  logic [LEN_WIDTH-1:0]   code_len    = '0;

  result_t pending_chars [$];   // characters owed by the block, oldest first
  result_t want;
  int      mismatches   = 0;
  int      ticks_sent   = 0;
  int      quiet_cycles = 0;
  int      idle_pct     = 0;    // chance per cycle that the sender holds off
  int      stall_pct    = 0;    // chance per cycle that the receiver stalls

  morse_key_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_down       (in_key_down),
    .in_space_pressed  (in_space_pressed),
    .in_delete_pressed (in_delete_pressed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol        (out_symbol),
    .out_kind          (out_kind),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Scoreboard: each result beat against the oldest owed character
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: result beat with nothing owed: symbol %0d kind %0d last %0b",
                 $time, out_symbol, out_kind, out_last);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_symbol !== want.symbol) begin
          $display("%0t: symbol expected %0d got %0d", $time, want.symbol, out_symbol);
          mismatches++;
        end
        if (out_kind !== want.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, want.kind, out_kind);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no beat on either side means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Counters stick at all ones rather than wrap
  function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Look up the gathered code and clear the letter in progress
  function automatic result_t close_letter();
    int         idx;
    logic [7:0] ch;
    result_t    beat;
    idx = (1 << code_len) - 2 + (int'(code_bits) % (1 << code_len));
    ch  = MORSE_CHARS[8*(29-idx) +: 8];
    beat.symbol = (ch == ".") ? SYM_NONE : ch[6:0];
    beat.kind   = (ch == ".") ? KIND_INVALID : KIND_LETTER;
    beat.last   = 1'b0;
    code_bits   = '0;
    code_len    = '0;
    gap_ticks   = '0;
    hold_ticks  = '0;
    mode        = KEY_IDLE;
    return beat;
  endfunction

  // One sample tick through the decoder image; owed characters go on the queue
  task automatic decode_tick(input logic key, input logic sp, input logic del);
    result_t beats [$];
    result_t beat;
    case (mode)
      KEY_HELD: begin
        if (key) begin
          hold_ticks = count_up(hold_ticks);
        end else begin
          // classified on the first key-up tick; a press equal to the threshold is a dot
          code_bits  = {code_bits[2:0], hold_ticks > dash_thr};
          code_len   = code_len + 3'd1;
          hold_ticks = '0;
          if (code_len >= MAX_LEN) begin
            beats.push_back(close_letter());
          end else begin
            mode      = KEY_GAP;
            gap_ticks = '0;
          end
        end
        space_ticks = '0;
        del_ticks   = '0;
      end
      KEY_GAP: begin
        if (key) begin
          mode       = KEY_HELD;
          hold_ticks = COUNT_WIDTH'(1);
          gap_ticks  = '0;
        end else begin
          gap_ticks = count_up(gap_ticks);
          // a zero timeout fires on the first counted tick, same as one
          if (gap_ticks >= gap_to) beats.push_back(close_letter());
        end
        space_ticks = '0;
        del_ticks   = '0;
      end
      default: begin
        mode = KEY_IDLE;
        if (key) begin
          mode        = KEY_HELD;
          hold_ticks  = COUNT_WIDTH'(1);
          code_bits   = '0;
          code_len    = '0;
          space_ticks = '0;
          del_ticks   = '0;
        end else begin
          beat.last = 1'b0;
          // space is owed ahead of backspace when both go up together
          if (sp) begin
            space_ticks = count_up(space_ticks);
          end else begin
            if (space_ticks > btn_thr) begin
              beat.symbol = SYM_SPACE;
              beat.kind   = KIND_SPACE;
              beats.push_back(beat);
            end
            space_ticks = '0;
          end
          if (del) begin
            del_ticks = count_up(del_ticks);
          end else begin
            if (del_ticks > btn_thr) begin
              beat.symbol = SYM_BACKSPACE;
              beat.kind   = KIND_BACKSPACE;
              beats.push_back(beat);
            end
            del_ticks = '0;
          end
        end
      end
    endcase
    foreach (beats[i]) begin
      beat      = beats[i];
      beat.last = (i == beats.size() - 1);
      pending_chars.push_back(beat);
    end
  endtask

  // Offer one sample; valid stays up between back-to-back samples
  task automatic send_tick(input logic key, input logic sp, input logic del);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_key_down       <= key;
    in_space_pressed  <= sp;
    in_delete_pressed <= del;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_tick(key, sp, del);
    ticks_sent++;
  endtask

  // Sender goes quiet until every owed character is in and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DASH_THRESHOLD:   dash_thr = val;
      CFG_GAP_TIMEOUT:      gap_to   = val;
      CFG_BUTTON_THRESHOLD: btn_thr  = val;
      default: ;
    endcase
  endtask

  task automatic load_timing(input logic [CFG_WIDTH-1:0] dash, input logic [CFG_WIDTH-1:0] gap,
                             input logic [CFG_WIDTH-1:0] btn);
    drain_results();
    write_reg(CFG_DASH_THRESHOLD, dash);
    write_reg(CFG_GAP_TIMEOUT, gap);
    write_reg(CFG_BUTTON_THRESHOLD, btn);
    write_reg(CFG_SPARE_INDEX, CFG_WIDTH'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_timing();
    load_timing(CFG_WIDTH'($urandom_range(1, 5)), CFG_WIDTH'($urandom_range(2, 9)),
                CFG_WIDTH'($urandom_range(0, 4)));
  endtask

  // A keyed letter of one to four elements; buttons rattle throughout and must be ignored.
  // Now and then a press sits exactly on the threshold or a gap runs out mid-letter.
  task automatic send_letter();
    int elems, len, gap, t;
    int dot_cap, gap_cap, gap_end;
    bit reach_dash;
    reach_dash = (dash_thr <= 24'd1000);
    dot_cap    = (dash_thr > 24'd6) ? 6 : int'(dash_thr);
    gap_cap    = (gap_to > 24'd8) ? 8 : ((gap_to == '0) ? 1 : int'(gap_to));
    gap_end    = (gap_to > 24'd64) ? 0 : ((gap_to == '0) ? 2 : int'(gap_to) + 1);
    elems      = $urandom_range(1, MAX_ELEMENTS);
    for (int e = 0; e < elems; e++) begin
      if (dot_cap == 0 || (reach_dash && $urandom_range(1) == 1)) begin
        len = int'(dash_thr) + $urandom_range(1, 3);
      end else begin
        len = $urandom_range(1, dot_cap);
      end
      if (reach_dash && dot_cap != 0 && $urandom_range(7) == 0) len = int'(dash_thr);
      for (t = 0; t < len; t++) begin
        send_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      if (e < elems - 1) begin
        gap = $urandom_range(1, gap_cap);
        if (gap_end != 0 && $urandom_range(9) == 0) gap = gap_end;
      end else begin
        gap = (gap_end == 0) ? $urandom_range(1, 3) : gap_end + $urandom_range(0, 2);
      end
      for (t = 0; t < gap; t++) begin
        send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Space, delete or both held around the threshold, then let go
  task automatic send_buttons();
    int which, base, sp_len, del_len, t;
    which   = $urandom_range(2);
    base    = (btn_thr > 24'd1000) ? 1 : int'(btn_thr);
    sp_len  = (which != 1) ? base + $urandom_range(0, 2) : 0;
    del_len = (which != 0) ? base + $urandom_range(0, 2) : 0;
    if (which == 2 && $urandom_range(1) == 1) del_len = sp_len;
    for (t = 0; t < sp_len || t < del_len; t++) begin
      send_tick(1'b0, t < sp_len, t < del_len);
    end
    send_tick(1'b0, 1'b0, 1'b0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // Mostly well-formed letters and button holds, the rest random samples
  task automatic run_traffic(input int count);
    int stop_at, pick;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) send_letter();
      else if (pick < 85) send_buttons();
      else send_noise();
    end
  endtask

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    load_timing(24'd1, 24'd2, 24'd1);
    // A: one-tick press equals the threshold so it is a dot, then a dash;
    // button presses meanwhile are wiped and their releases ignored
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0);
    // four dashes: not a letter, flagged invalid on the fourth release, no gap wait
    repeat (4) begin
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
    end
    // both buttons let go on one tick: space, then backspace carrying last
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    load_random_timing();
    run_traffic(350);
  endtask

  // Zero everywhere: every press a dash, one-tick gap, any button hold counts
  task automatic test_low_extremes();
    load_timing('0, '0, '0);
    run_traffic(120);
  endtask

  // All ones: only dots, letters close on the fourth element, buttons never count
  task automatic test_high_extremes();
    load_timing(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
    run_traffic(120);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 88;
    stall_pct = 0;
    load_random_timing();
    run_traffic(220);
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 88;
    load_random_timing();
    run_traffic(220);
  endtask

  task automatic test_mixed_idling();
    idle_pct  = 17;
    stall_pct = 17;
    load_timing(CFG_WIDTH'($urandom_range(1, 5)), 24'd1, CFG_WIDTH'($urandom_range(0, 4)));
    run_traffic(200);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_back_to_back();
    test_low_extremes();
    test_high_extremes();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    drain_results();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
